// ----- rtl/core/escaped_packet_receiver_assert.svh -----
// assertion macros for the escaped packet receiver checker
`ifndef ESCAPED_PACKET_RECEIVER_ASSERT_SVH
`define ESCAPED_PACKET_RECEIVER_ASSERT_SVH

// clocked assertion, disabled while reset is held
`define EPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define EPR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/epr_pkg.sv -----
// shared types and constants for the escaped packet receiver
package epr_pkg;

  localparam int PAYLOAD_BYTES_DEF = 32;

  localparam int BYTE_W   = 8;
  localparam int LENGTH_W = 6;
  localparam int INDEX_W  = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] NODE_ADDRESS_RST = 8'd48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_ADDRESS = 2'd0,
    CFG_ESC_BYTE     = 2'd1,
    CFG_HDR_BYTE     = 2'd2,
    CFG_TERM_BYTE    = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_HDR  = 3'd2,
    PH_SRC  = 3'd3,
    PH_PORT = 3'd4,
    PH_DATA = 3'd5,
    PH_DESC = 3'd6
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              framing_error;
    logic              overrun_error;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] node_address;
    logic [BYTE_W-1:0] esc_byte;
    logic [BYTE_W-1:0] hdr_byte;
    logic [BYTE_W-1:0] term_byte;
  } cfg_t;

  typedef struct packed {
    logic                packet_done;
    logic [LENGTH_W-1:0] packet_length;
    logic [BYTE_W-1:0]   source_addr;
    logic [BYTE_W-1:0]   port_id;
    logic                store_valid;
    logic [INDEX_W-1:0]  store_index;
    logic [BYTE_W-1:0]   store_byte;
  } result_t;

endpackage

// ----- rtl/core/epr_in_reg.sv -----
// input register stage holding one received byte transaction
module epr_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  epr_pkg::item_t  in_item,
  input  logic            advance,
  output logic            in_stall,
  output logic            s1_valid,
  output epr_pkg::item_t  s1_item
);

  logic           valid_r;
  logic           valid_nxt;
  logic           take;
  epr_pkg::item_t item_r;

  assign in_stall  = valid_r && !advance;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = take || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ----- rtl/core/epr_core.sv -----
// frame decoder state machine and packet registers
module epr_core #(
  parameter int PAYLOAD_BYTES = epr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  epr_pkg::item_t    item,
  input  epr_pkg::cfg_t     cfg,
  output epr_pkg::result_t  result
);

  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(PAYLOAD_BYTES);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PAYLOAD_BYTES - 1);

  epr_pkg::phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  logic [epr_pkg::BYTE_W-1:0] src_r, src_nxt;
  logic [epr_pkg::BYTE_W-1:0] port_r, port_nxt;

  logic [epr_pkg::BYTE_W-1:0] b;
  logic err, is_esc, room;
  logic st_valid;
  logic [CNT_W-1:0] st_index;
  logic [epr_pkg::BYTE_W-1:0] st_byte;

  assign b      = item.rx_byte;
  assign err    = item.framing_error || item.overrun_error;
  assign is_esc = (b == cfg.esc_byte);
  assign room   = (cnt_r < CNT_MAX);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (err) begin
      phase_nxt = epr_pkg::PH_IDLE;
    end else begin
      case (phase_r)
        epr_pkg::PH_IDLE: phase_nxt = is_esc ? epr_pkg::PH_ESC : epr_pkg::PH_IDLE;
        epr_pkg::PH_ESC:
          phase_nxt = (b == cfg.hdr_byte) ? epr_pkg::PH_HDR : epr_pkg::PH_IDLE;
        epr_pkg::PH_HDR: begin
          if (b == cfg.node_address) phase_nxt = epr_pkg::PH_SRC;
          else if (is_esc)           phase_nxt = epr_pkg::PH_ESC;
          else                       phase_nxt = epr_pkg::PH_IDLE;
        end
        epr_pkg::PH_SRC:  phase_nxt = is_esc ? epr_pkg::PH_ESC : epr_pkg::PH_PORT;
        epr_pkg::PH_PORT: phase_nxt = is_esc ? epr_pkg::PH_ESC : epr_pkg::PH_DATA;
        epr_pkg::PH_DATA: begin
          if (!room)       phase_nxt = epr_pkg::PH_IDLE;
          else if (is_esc) phase_nxt = epr_pkg::PH_DESC;
          else             phase_nxt = epr_pkg::PH_DATA;
        end
        epr_pkg::PH_DESC: phase_nxt = is_esc ? epr_pkg::PH_DATA : epr_pkg::PH_IDLE;
        default:          phase_nxt = epr_pkg::PH_IDLE;
      endcase
    end
  end

  // packet registers and store stroke
  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    src_nxt  = src_r;
    port_nxt = port_r;
    st_valid = 1'b0;
    st_index = '0;
    st_byte  = '0;
    if (!err) begin
      case (phase_r)
        epr_pkg::PH_SRC: begin
          if (!is_esc) begin
            src_nxt  = b;
            done_nxt = 1'b0;
            cnt_nxt  = '0;
          end
        end
        epr_pkg::PH_PORT: begin
          if (!is_esc) begin
            port_nxt = b;
          end
        end
        epr_pkg::PH_DATA: begin
          if (room) begin
            st_valid = 1'b1;
            st_index = cnt_r;
            st_byte  = b;
            cnt_nxt  = cnt_r + 1'b1;
          end else begin
            cnt_nxt  = CNT_FULL;
            done_nxt = 1'b1;
          end
        end
        epr_pkg::PH_DESC: begin
          if (!is_esc && (b == cfg.term_byte)) begin
            done_nxt = 1'b1;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= epr_pkg::PH_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      src_r   <= '0;
      port_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      src_r   <= src_nxt;
      port_r  <= port_nxt;
    end
  end

  always_comb begin
    result.packet_done   = done_nxt;
    result.packet_length = epr_pkg::LENGTH_W'(cnt_nxt);
    result.source_addr   = src_nxt;
    result.port_id       = port_nxt;
    result.store_valid   = st_valid;
    result.store_index   = epr_pkg::INDEX_W'(st_index);
    result.store_byte    = st_byte;
  end

endmodule

// ----- rtl/core/epr_out_reg.sv -----
// result register holding one output transaction until taken
module epr_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  epr_pkg::result_t  result,
  input  logic              out_stall,
  output logic              advance,
  output logic              load,
  output logic              out_valid,
  output epr_pkg::result_t  out_result
);

  logic             valid_r, valid_nxt;
  epr_pkg::result_t result_r;

  assign advance   = !valid_r || !out_stall;
  assign load      = s1_valid && advance;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ----- rtl/core/escaped_packet_receiver.sv -----
// Escaped packet receiver: takes one received serial byte per transaction and
// decodes ESC/HEADER framed, addressed packets, reporting each payload write as
// an indexed store stroke along with the current packet status. One transaction
// is accepted every cycle while in_stall is low; each produces exactly one result
// through an input register, the combinational decoder update and a result
// register. in_stall rises only when both registers hold data and out_stall is
// high. Configuration writes take effect at the next edge and are meant for
// when no transaction is in flight.
module escaped_packet_receiver #(
  parameter int PAYLOAD_BYTES = epr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [epr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [epr_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [epr_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic                          in_framing_error,
  input  logic                          in_overrun_error,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_packet_done,
  output logic [epr_pkg::LENGTH_W-1:0]  out_packet_length,
  output logic [epr_pkg::BYTE_W-1:0]    out_source_addr,
  output logic [epr_pkg::BYTE_W-1:0]    out_port_id,
  output logic                          out_store_valid,
  output logic [epr_pkg::INDEX_W-1:0]   out_store_index,
  output logic [epr_pkg::BYTE_W-1:0]    out_store_byte
);

  epr_pkg::cfg_t    cfg_r;
  epr_pkg::item_t   in_item, s1_item;
  epr_pkg::result_t result, out_result;
  logic             s1_valid, advance, load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_address <= epr_pkg::NODE_ADDRESS_RST;
      cfg_r.esc_byte     <= '0;
      cfg_r.hdr_byte     <= '0;
      cfg_r.term_byte    <= '0;
    end else if (cfg_we) begin
      case (epr_pkg::cfg_index_t'(cfg_index))
        epr_pkg::CFG_NODE_ADDRESS: cfg_r.node_address <= cfg_data;
        epr_pkg::CFG_ESC_BYTE:     cfg_r.esc_byte     <= cfg_data;
        epr_pkg::CFG_HDR_BYTE:     cfg_r.hdr_byte     <= cfg_data;
        epr_pkg::CFG_TERM_BYTE:    cfg_r.term_byte    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_item.rx_byte       = in_rx_byte;
  assign in_item.framing_error = in_framing_error;
  assign in_item.overrun_error = in_overrun_error;

  epr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .advance  (advance),
    .in_stall (in_stall),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  epr_core #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (load),
    .item   (s1_item),
    .cfg    (cfg_r),
    .result (result)
  );

  epr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .result     (result),
    .out_stall  (out_stall),
    .advance    (advance),
    .load       (load),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  assign out_packet_done   = out_result.packet_done;
  assign out_packet_length = out_result.packet_length;
  assign out_source_addr   = out_result.source_addr;
  assign out_port_id       = out_result.port_id;
  assign out_store_valid   = out_result.store_valid;
  assign out_store_index   = out_result.store_index;
  assign out_store_byte    = out_result.store_byte;

endmodule

// ----- rtl/core/epr_checker.sv -----
// port-level assertions for the escaped packet receiver, bound to the top level
`include "escaped_packet_receiver_assert.svh"

module epr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_packet_done,
  input logic [epr_pkg::LENGTH_W-1:0]  out_packet_length,
  input logic [epr_pkg::BYTE_W-1:0]    out_source_addr,
  input logic [epr_pkg::BYTE_W-1:0]    out_port_id,
  input logic                          out_store_valid,
  input logic [epr_pkg::INDEX_W-1:0]   out_store_index,
  input logic [epr_pkg::BYTE_W-1:0]    out_store_byte
);

  `EPR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_store_byte) && $stable(out_packet_length) && $stable(out_source_addr), "stalled output transaction changed")
  `EPR_ASSERT(a_store_not_done, out_valid && out_store_valid |-> !out_packet_done, "store stroke while packet marked done")
  `EPR_ASSERT(a_idle_stroke_zero, out_valid && !out_store_valid |-> (out_store_index == '0) && (out_store_byte == '0), "store fields nonzero without store stroke")
  `EPR_ASSERT(a_len_follows_index, out_valid && out_store_valid |-> out_packet_length[epr_pkg::INDEX_W-1:0] == epr_pkg::INDEX_W'(out_store_index + 1'b1), "length does not follow store index")
  `EPR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind escaped_packet_receiver epr_checker u_epr_checker (.*);

// ----- sim/tb_escaped_packet_receiver.sv -----
// testbench for the escaped packet receiver with directed and random byte streams
module tb_escaped_packet_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD     = epr_pkg::PAYLOAD_BYTES_DEF;
  localparam int HOLD_CYCLES = 120;
  localparam int QUIET_LIMIT = 2000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  epr_pkg::cfg_index_t           cfg_index = epr_pkg::CFG_NODE_ADDRESS;
  logic [epr_pkg::BYTE_W-1:0]    cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [epr_pkg::BYTE_W-1:0]    in_rx_byte = '0;
  logic                          in_framing_error = 1'b0;
  logic                          in_overrun_error = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_packet_done;
  logic [epr_pkg::LENGTH_W-1:0]  out_packet_length;
  logic [epr_pkg::BYTE_W-1:0]    out_source_addr;
  logic [epr_pkg::BYTE_W-1:0]    out_port_id;
  logic                          out_store_valid;
  logic [epr_pkg::INDEX_W-1:0]   out_store_index;
  logic [epr_pkg::BYTE_W-1:0]    out_store_byte;

  escaped_packet_receiver #(.PAYLOAD_BYTES(PAYLOAD)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .in_framing_error(in_framing_error),
    .in_overrun_error(in_overrun_error),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_packet_done(out_packet_done),
    .out_packet_length(out_packet_length),
    .out_source_addr(out_source_addr),
    .out_port_id(out_port_id),
    .out_store_valid(out_store_valid),
    .out_store_index(out_store_index),
    .out_store_byte(out_store_byte)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  epr_pkg::cfg_t              codes = {epr_pkg::NODE_ADDRESS_RST, 8'h00, 8'h00, 8'h00};
  epr_pkg::phase_t            rx_ph = epr_pkg::PH_IDLE;
  int                         stored = 0;
  logic                       pkt_done = 1'b0;
  logic [epr_pkg::BYTE_W-1:0] pkt_src = '0;
  logic [epr_pkg::BYTE_W-1:0] pkt_port = '0;

  epr_pkg::result_t decoded_q[$];
  int      fail_count = 0;
  int      items_fed = 0;
  int      hold_req = 0;
  bit      tx_gaps = 1'b1;
  bit      rx_gaps = 1'b1;
  int      frame_pos;
  int      fault_at;

  function automatic epr_pkg::result_t decode_byte(input logic [epr_pkg::BYTE_W-1:0] b,
                                                   input logic fe, input logic oe);
    epr_pkg::result_t r;
    r = '0;
    if (fe || oe) begin
      rx_ph = epr_pkg::PH_IDLE;
    end else begin
      case (rx_ph)
        epr_pkg::PH_IDLE: begin
          if (b == codes.esc_byte) rx_ph = epr_pkg::PH_ESC;
        end
        epr_pkg::PH_ESC: begin
          rx_ph = (b == codes.hdr_byte) ? epr_pkg::PH_HDR : epr_pkg::PH_IDLE;
        end
        epr_pkg::PH_HDR: begin
          if (b == codes.node_address) rx_ph = epr_pkg::PH_SRC;
          else if (b == codes.esc_byte) rx_ph = epr_pkg::PH_ESC;
          else rx_ph = epr_pkg::PH_IDLE;
        end
        epr_pkg::PH_SRC: begin
          if (b == codes.esc_byte) begin
            rx_ph = epr_pkg::PH_ESC;
          end else begin
            rx_ph = epr_pkg::PH_PORT;
            pkt_src = b;
            pkt_done = 1'b0;
            stored = 0;
          end
        end
        epr_pkg::PH_PORT: begin
          if (b == codes.esc_byte) begin
            rx_ph = epr_pkg::PH_ESC;
          end else begin
            rx_ph = epr_pkg::PH_DATA;
            pkt_port = b;
          end
        end
        epr_pkg::PH_DATA: begin
          if (stored < PAYLOAD) begin
            r.store_valid = 1'b1;
            r.store_index = stored[epr_pkg::INDEX_W-1:0];
            r.store_byte = b;
            stored++;
            if (b == codes.esc_byte) rx_ph = epr_pkg::PH_DESC;
          end else begin
            stored = PAYLOAD - 1;
            pkt_done = 1'b1;
            rx_ph = epr_pkg::PH_IDLE;
          end
        end
        epr_pkg::PH_DESC: begin
          if (b == codes.esc_byte) begin
            rx_ph = epr_pkg::PH_DATA;
          end else if (b == codes.term_byte) begin
            pkt_done = 1'b1;
            if (stored > 0) stored--;
            rx_ph = epr_pkg::PH_IDLE;
          end else begin
            rx_ph = epr_pkg::PH_IDLE;
          end
        end
        default: rx_ph = epr_pkg::PH_IDLE;
      endcase
    end
    r.packet_done = pkt_done;
    r.packet_length = stored[epr_pkg::LENGTH_W-1:0];
    r.source_addr = pkt_src;
    r.port_id = pkt_port;
    return r;
  endfunction

  task automatic send_byte(input logic [epr_pkg::BYTE_W-1:0] b, input logic fe,
                           input logic oe);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_framing_error <= fe;
    in_overrun_error <= oe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decoded_q.push_back(decode_byte(b, fe, oe));
    items_fed++;
  endtask

  task automatic feed(input logic [epr_pkg::BYTE_W-1:0] b);
    send_byte(b, 1'b0, 1'b0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input epr_pkg::cfg_index_t idx,
                           input logic [epr_pkg::BYTE_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      epr_pkg::CFG_NODE_ADDRESS: codes.node_address = val;
      epr_pkg::CFG_ESC_BYTE:     codes.esc_byte = val;
      epr_pkg::CFG_HDR_BYTE:     codes.hdr_byte = val;
      epr_pkg::CFG_TERM_BYTE:    codes.term_byte = val;
      default: ;
    endcase
  endtask

  task automatic load_codes(input logic [7:0] node, input logic [7:0] esc,
                            input logic [7:0] hdr, input logic [7:0] term);
    write_reg(epr_pkg::CFG_NODE_ADDRESS, node);
    write_reg(epr_pkg::CFG_ESC_BYTE, esc);
    write_reg(epr_pkg::CFG_HDR_BYTE, hdr);
    write_reg(epr_pkg::CFG_TERM_BYTE, term);
  endtask

  task automatic frame_byte(input logic [epr_pkg::BYTE_W-1:0] b);
    logic fe;
    logic oe;
    fe = 1'b0;
    oe = 1'b0;
    if (frame_pos == fault_at) begin
      fe = ($urandom_range(0, 1) == 1);
      oe = !fe || ($urandom_range(0, 1) == 1);
    end
    send_byte(b, fe, oe);
    frame_pos++;
  endtask

  task automatic send_frame();
    logic [epr_pkg::BYTE_W-1:0] d;
    int len;
    int sel;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 12);
    frame_pos = 0;
    fault_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len + 6) : -1;
    frame_byte(codes.esc_byte);
    frame_byte(($urandom_range(0, 15) == 0) ? 8'($urandom) : codes.hdr_byte);
    frame_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : codes.node_address);
    frame_byte(($urandom_range(0, 29) == 0) ? codes.esc_byte : 8'($urandom));
    frame_byte(($urandom_range(0, 29) == 0) ? codes.esc_byte : 8'($urandom));
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      if ($urandom_range(0, 7) == 0 || (i == PAYLOAD && $urandom_range(0, 1) == 1))
        d = codes.esc_byte;
      frame_byte(d);
      if (d == codes.esc_byte && i < PAYLOAD) frame_byte(codes.esc_byte);
    end
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      frame_byte(codes.esc_byte);
      frame_byte(codes.term_byte);
    end else if (sel == 8) begin
      frame_byte(codes.esc_byte);
      frame_byte(8'($urandom));
    end
  endtask

  task automatic run_traffic(input int count);
    int goal;
    int sel;
    goal = items_fed + count;
    while (items_fed < goal) begin
      sel = $urandom_range(0, 19);
      if (sel < 16) begin
        send_frame();
      end else if (sel < 18) begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
      end else begin
        feed(codes.esc_byte);
        if (sel == 18) feed(8'($urandom));
      end
    end
    settle();
  endtask

  task automatic test_reset_codes();
    feed(8'h00);
    feed(8'h00);
    feed(epr_pkg::NODE_ADDRESS_RST);
    feed(8'h41);
    feed(8'h07);
    feed(8'hFF);
    feed(8'h00);
    feed(8'h00);
    send_byte(8'h12, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_escaped_frame();
    load_codes(8'h5A, 8'h7E, 8'hA5, 8'h7D);
    feed(8'h7E);
    feed(8'hA5);
    feed(8'h5A);
    feed(8'h01);
    feed(8'h80);
    feed(8'h00);
    feed(8'h7E);
    feed(8'h7E);
    feed(8'hFF);
    feed(8'h7E);
    feed(8'h7D);
    settle();
  endtask

  task automatic test_error_flags();
    feed(8'h7E);
    feed(8'hA5);
    send_byte(8'h5A, 1'b1, 1'b0);
    feed(8'h5A);
    feed(8'h7E);
    feed(8'h00);
    feed(8'h7E);
    feed(8'hA5);
    feed(8'h7E);
    feed(8'hA5);
    feed(8'h5A);
    send_byte(8'h33, 1'b0, 1'b1);
    feed(8'h7E);
    feed(8'hA5);
    feed(8'h5A);
    feed(8'h10);
    feed(8'h20);
    feed(8'h7E);
    feed(8'h3C);
    settle();
  endtask

  task automatic test_output_hold();
    hold_req <= hold_req + 1;
    repeat (4) send_frame();
    settle();
  endtask

  task automatic test_random_frames();
    run_traffic(480);
  endtask

  task automatic test_extreme_codes();
    load_codes(8'hFF, 8'h00, 8'hFF, 8'h01);
    run_traffic(450);
    load_codes(8'h00, 8'hFF, 8'h00, 8'hFE);
    run_traffic(450);
    load_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_traffic(200);
  endtask

  task automatic test_address_is_escape();
    load_codes(8'h10, 8'h10, 8'h20, 8'h30);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_traffic(300);
  endtask

  initial begin : receiver_side
    int seen_hold;
    seen_hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req != seen_hold) begin
        seen_hold = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : status_check
    epr_pkg::result_t seen;
    epr_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_packet_done, out_packet_length, out_source_addr, out_port_id,
              out_store_valid, out_store_index, out_store_byte};
      if (decoded_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected transaction: %h", seen);
      end else begin
        want = decoded_q.pop_front();
        if (seen.packet_done !== want.packet_done ||
            seen.packet_length !== want.packet_length ||
            seen.source_addr !== want.source_addr ||
            seen.port_id !== want.port_id ||
            seen.store_valid !== want.store_valid ||
            seen.store_index !== want.store_index ||
            seen.store_byte !== want.store_byte) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("expected done=%b len=%0d src=%h port=%h store=%b idx=%0d byte=%h",
                     want.packet_done, want.packet_length, want.source_addr, want.port_id,
                     want.store_valid, want.store_index, want.store_byte);
            $display("actual   done=%b len=%0d src=%h port=%h store=%b idx=%0d byte=%h",
                     seen.packet_done, seen.packet_length, seen.source_addr, seen.port_id,
                     seen.store_valid, seen.store_index, seen.store_byte);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_codes();
    test_escaped_frame();
    test_error_flags();
    test_output_hold();
    test_random_frames();
    test_extreme_codes();
    test_address_is_escape();
    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/epr_pkg.sv
rtl/core/epr_in_reg.sv
rtl/core/epr_core.sv
rtl/core/epr_out_reg.sv
rtl/core/escaped_packet_receiver.sv
rtl/core/epr_checker.sv
sim/tb_escaped_packet_receiver.sv
